[rtl/core/cpi_pkg.sv]
// ----------------------------------------------------------------------------
// Charged particle integrator package
// Shared widths, register addresses, datapath operation codes and the
// saturating fixed point helper.
// ----------------------------------------------------------------------------
package cpi_pkg;

   localparam int FracBits = 16;
   localparam int DataW    = 32;
   localparam int AddrW    = 5;
   localparam int OpW      = 4;
   localparam int SelW     = 4;

   // Register byte addresses.
   localparam logic [AddrW-1:0] ADDR_MODE   = 5'd0;
   localparam logic [AddrW-1:0] ADDR_DT     = 5'd4;
   localparam logic [AddrW-1:0] ADDR_LAMBDA = 5'd8;
   localparam logic [AddrW-1:0] ADDR_B0     = 5'd12;
   localparam logic [AddrW-1:0] ADDR_KAPPA  = 5'd16;
   localparam logic [AddrW-1:0] ADDR_EFIELD = 5'd20;

   // Scheme codes.
   localparam logic [1:0] MODE_EULER  = 2'd0;
   localparam logic [1:0] MODE_CROMER = 2'd1;
   localparam logic [1:0] MODE_RK2    = 2'd2;
   localparam logic [1:0] MODE_VERLET = 2'd3;

   // Operand and destination selects of the datapath register file.
   localparam logic [SelW-1:0] R_X     = 4'd0;
   localparam logic [SelW-1:0] R_Y     = 4'd1;
   localparam logic [SelW-1:0] R_VX    = 4'd2;
   localparam logic [SelW-1:0] R_VY    = 4'd3;
   localparam logic [SelW-1:0] R_T0    = 4'd4;  // scratch
   localparam logic [SelW-1:0] R_B     = 4'd5;
   localparam logic [SelW-1:0] R_H     = 4'd6;
   localparam logic [SelW-1:0] R_DT    = 4'd7;
   localparam logic [SelW-1:0] R_LAM   = 4'd8;
   localparam logic [SelW-1:0] R_B0    = 4'd9;
   localparam logic [SelW-1:0] R_KAP   = 4'd10;
   localparam logic [SelW-1:0] R_E     = 4'd11;
   localparam logic [SelW-1:0] R_ONE   = 4'd12;
   localparam logic [SelW-1:0] R_HALF  = 4'd13;
   localparam logic [SelW-1:0] R_XM    = 4'd14;  // midpoint values
   localparam logic [SelW-1:0] R_VXM   = 4'd15;

   // Datapath operations.
   localparam logic [OpW-1:0] OP_NOP  = 4'd0;
   localparam logic [OpW-1:0] OP_MUL  = 4'd1;  // d = a*b
   localparam logic [OpW-1:0] OP_ADD  = 4'd2;  // d = a+b
   localparam logic [OpW-1:0] OP_SUB  = 4'd3;  // d = a-b
   localparam logic [OpW-1:0] OP_MAC  = 4'd4;  // d = c + a*b
   localparam logic [OpW-1:0] OP_LOAD = 4'd5;  // take the init fields
   localparam logic [OpW-1:0] OP_CLR  = 4'd6;  // clear the clip flag

   typedef struct packed {
      logic [OpW-1:0]  op;
      logic [SelW-1:0] src_a;
      logic [SelW-1:0] src_b;
      logic [SelW-1:0] src_c;
      logic [SelW-1:0] dst;
   } cmd_type;

   localparam logic signed [63:0] QMax = 64'sd2147483647;
   localparam logic signed [63:0] QMin = -64'sd2147483648;

   // Saturate a wide value to 32 bits; bit 32 of the result flags a clip.
   function automatic logic [DataW:0] sat32(input logic signed [65:0] v);
      logic [DataW:0] r;
      if (v > 66'(QMax)) begin
         r = {1'b1, QMax[DataW-1:0]};
      end else if (v < 66'(QMin)) begin
         r = {1'b1, QMin[DataW-1:0]};
      end else begin
         r = {1'b0, v[DataW-1:0]};
      end
      return r;
   endfunction

endpackage

[rtl/core/cpi_datapath.sv]
// ----------------------------------------------------------------------------
// Charged particle integrator datapath
// Register file of state, constants and scratch values with one shared
// 32x32 multiplier. A product is registered, then rounded and optionally
// added in the following cycle.
// ----------------------------------------------------------------------------
module cpi_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  cpi_pkg::cmd_type          cmd,
   input  logic                      mul_phase,
   input  logic signed [31:0]        init_x,
   input  logic signed [31:0]        init_y,
   input  logic signed [31:0]        init_vx,
   input  logic signed [31:0]        init_vy,
   input  logic signed [31:0]        cfg_dt,
   input  logic signed [31:0]        cfg_lambda,
   input  logic signed [31:0]        cfg_b0,
   input  logic signed [31:0]        cfg_kappa,
   input  logic signed [31:0]        cfg_efield,
   output logic signed [31:0]        st_x,
   output logic signed [31:0]        st_y,
   output logic signed [31:0]        st_vx,
   output logic signed [31:0]        st_vy,
   output logic                      clip
);

   logic signed [31:0] rf_ff [16];
   logic signed [31:0] opa, opb, opc;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [64:0] rnd;
   logic signed [65:0] wide;
   logic [32:0]        s1, s2;
   logic signed [31:0] res;
   logic               res_clip;
   logic               clip_ff, clip_in;

   // Fixed config/constant slots: all on a; b dt,lam,E,one,half; c E,one.
   always_comb begin
      opa = rf_ff[cmd.src_a];
      opb = rf_ff[cmd.src_b];
      opc = rf_ff[cmd.src_c];
      case (cmd.src_a)
         cpi_pkg::R_DT:   opa = cfg_dt;
         cpi_pkg::R_LAM:  opa = cfg_lambda;
         cpi_pkg::R_B0:   opa = cfg_b0;
         cpi_pkg::R_KAP:  opa = cfg_kappa;
         cpi_pkg::R_E:    opa = cfg_efield;
         cpi_pkg::R_ONE:  opa = 32'sd1 <<< cpi_pkg::FracBits;
         cpi_pkg::R_HALF: opa = 32'sd1 <<< (cpi_pkg::FracBits - 1);
         default:         opa = rf_ff[cmd.src_a];
      endcase
      case (cmd.src_b)
         cpi_pkg::R_DT:   opb = cfg_dt;
         cpi_pkg::R_LAM:  opb = cfg_lambda;
         cpi_pkg::R_E:    opb = cfg_efield;
         cpi_pkg::R_ONE:  opb = 32'sd1 <<< cpi_pkg::FracBits;
         cpi_pkg::R_HALF: opb = 32'sd1 <<< (cpi_pkg::FracBits - 1);
         default:         opb = rf_ff[cmd.src_b];
      endcase
      case (cmd.src_c)
         cpi_pkg::R_E:    opc = cfg_efield;
         cpi_pkg::R_ONE:  opc = 32'sd1 <<< cpi_pkg::FracBits;
         default:         opc = rf_ff[cmd.src_c];
      endcase
   end

   // Multiplier stage.
   assign prod_in = opa * opb;

   // Round half up, floor shift, saturate; MAC adds c, ADD/SUB take a and b.
   always_comb begin
      rnd = 65'(prod_ff) + (65'sd1 <<< (cpi_pkg::FracBits - 1));
      s1  = cpi_pkg::sat32(66'(rnd >>> cpi_pkg::FracBits));
      wide = '0;
      case (cmd.op)
         cpi_pkg::OP_MUL: wide = 66'(signed'(s1[31:0]));
         cpi_pkg::OP_MAC: wide = 66'(opc) + 66'(signed'(s1[31:0]));
         cpi_pkg::OP_ADD: wide = 66'(opa) + 66'(opb);
         cpi_pkg::OP_SUB: wide = 66'(opa) - 66'(opb);
         default:         wide = '0;
      endcase
      s2  = cpi_pkg::sat32(wide);
      res = signed'(s2[31:0]);
      res_clip = s2[32] || ((cmd.op == cpi_pkg::OP_MUL || cmd.op == cpi_pkg::OP_MAC)
                            && s1[32]);
   end

   // Write back. A multiply writes back in its mul_phase, once its product is registered.
   always_comb begin
      clip_in = clip_ff;
      if (cmd.op == cpi_pkg::OP_CLR || cmd.op == cpi_pkg::OP_LOAD) begin
         clip_in = 1'b0;
      end else if (cmd.op == cpi_pkg::OP_ADD || cmd.op == cpi_pkg::OP_SUB
                   || mul_phase) begin
         clip_in = clip_ff | res_clip;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         clip_ff  <= 1'b0;
         rf_ff[0] <= '0;
         rf_ff[1] <= '0;
         rf_ff[2] <= '0;
         rf_ff[3] <= '0;
      end else begin
         clip_ff <= clip_in;
         if (cmd.op == cpi_pkg::OP_LOAD) begin
            rf_ff[0] <= init_x;
            rf_ff[1] <= init_y;
            rf_ff[2] <= init_vx;
            rf_ff[3] <= init_vy;
         end else if (cmd.op == cpi_pkg::OP_ADD || cmd.op == cpi_pkg::OP_SUB
                      || ((cmd.op == cpi_pkg::OP_MUL || cmd.op == cpi_pkg::OP_MAC)
                          && mul_phase)) begin
            rf_ff[cmd.dst] <= res;
         end
      end
   end

   assign st_x  = rf_ff[0];
   assign st_y  = rf_ff[1];
   assign st_vx = rf_ff[2];
   assign st_vy = rf_ff[3];
   assign clip  = clip_ff;

endmodule

[rtl/core/cpi_controller.sv]
// ----------------------------------------------------------------------------
// Charged particle integrator controller
// Sequences one load or one time step as a list of register file operations.
// Each multiply holds its command for a product phase and a write phase.
// ----------------------------------------------------------------------------
module cpi_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 start_kind,
   input  logic [1:0]           mode,
   input  logic                 result_free,
   output cpi_pkg::cmd_type     cmd,
   output logic                 mul_phase,
   output logic                 done
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [5:0] pc_ff, pc_in;
   logic       phase_ff, phase_in;
   logic [1:0] mode_ff, mode_in;
   logic       last;
   cpi_pkg::cmd_type c;

   function automatic cpi_pkg::cmd_type mk(input logic [3:0] op, input logic [3:0] a,
                                           input logic [3:0] b, input logic [3:0] cc,
                                           input logic [3:0] d);
      cpi_pkg::cmd_type r;
      r.op = op; r.src_a = a; r.src_b = b; r.src_c = cc; r.dst = d;
      return r;
   endfunction

   // Microprogram: returns the operation at pc for a scheme; last flags the end.
   always_comb begin
      c    = mk(cpi_pkg::OP_NOP, '0, '0, '0, '0);
      last = 1'b0;
      if (pc_ff == 6'd0) begin
         c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_DT, cpi_pkg::R_HALF, '0, cpi_pkg::R_H);
      end else if (pc_ff == 6'd1) begin
         // b = B0 * sat(one + kappa*x)
         c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_KAP, cpi_pkg::R_X, cpi_pkg::R_ONE,
                cpi_pkg::R_T0);
      end else if (pc_ff == 6'd2) begin
         c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B0, cpi_pkg::R_T0, '0, cpi_pkg::R_B);
      end else begin
         case (mode_ff)
            cpi_pkg::MODE_EULER: begin
               // T0 spare: compute ax into XM, ay into VXM, then updates.
               case (pc_ff)
                  6'd3: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_B, '0, cpi_pkg::R_T0);
                  6'd4: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_T0, cpi_pkg::R_VY, '0, cpi_pkg::R_XM);
                  6'd5: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B, cpi_pkg::R_VX, '0, cpi_pkg::R_T0);
                  6'd6: c = mk(cpi_pkg::OP_SUB, cpi_pkg::R_E, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd7: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_T0, '0, cpi_pkg::R_VXM);
                  6'd8: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VX, cpi_pkg::R_DT, cpi_pkg::R_X, cpi_pkg::R_X);
                  6'd9: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VY, cpi_pkg::R_DT, cpi_pkg::R_Y, cpi_pkg::R_Y);
                  6'd10: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_XM, cpi_pkg::R_DT, cpi_pkg::R_VX, cpi_pkg::R_VX);
                  6'd11: begin
                     c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VXM, cpi_pkg::R_DT, cpi_pkg::R_VY, cpi_pkg::R_VY);
                     last = 1'b1;
                  end
                  default: last = 1'b1;
               endcase
            end
            cpi_pkg::MODE_CROMER: begin
               case (pc_ff)
                  6'd3: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_B, '0, cpi_pkg::R_T0);
                  6'd4: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_T0, cpi_pkg::R_VY, '0, cpi_pkg::R_T0);
                  6'd5: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_DT, cpi_pkg::R_VX, cpi_pkg::R_VX);
                  6'd6: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B, cpi_pkg::R_VX, '0, cpi_pkg::R_T0);
                  6'd7: c = mk(cpi_pkg::OP_SUB, cpi_pkg::R_E, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd8: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd9: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_DT, cpi_pkg::R_VY, cpi_pkg::R_VY);
                  6'd10: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VX, cpi_pkg::R_DT, cpi_pkg::R_X, cpi_pkg::R_X);
                  6'd11: begin
                     c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VY, cpi_pkg::R_DT, cpi_pkg::R_Y, cpi_pkg::R_Y);
                     last = 1'b1;
                  end
                  default: last = 1'b1;
               endcase
            end
            cpi_pkg::MODE_RK2: begin
               // B holds b; T0 scratch; XM, VXM midpoint; H holds dt*0.5 throughout.
               // Slot order: xm -> XM, vxm -> VXM, vym -> B once b is no longer needed,
               // then bm -> XM once xm has been used.
               case (pc_ff)
                  6'd3: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_B, '0, cpi_pkg::R_T0);
                  6'd4: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_T0, cpi_pkg::R_VY, '0, cpi_pkg::R_T0);
                  6'd5: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_H, cpi_pkg::R_VX, cpi_pkg::R_VXM);
                  6'd6: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B, cpi_pkg::R_VX, '0, cpi_pkg::R_T0);
                  6'd7: c = mk(cpi_pkg::OP_SUB, cpi_pkg::R_E, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd8: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  // vym into B (b no longer needed)
                  6'd9: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_H, cpi_pkg::R_VY, cpi_pkg::R_B);
                  6'd10: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VX, cpi_pkg::R_H, cpi_pkg::R_X, cpi_pkg::R_XM);
                  // bm into XM
                  6'd11: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_KAP, cpi_pkg::R_XM, cpi_pkg::R_ONE, cpi_pkg::R_T0);
                  6'd12: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B0, cpi_pkg::R_T0, '0, cpi_pkg::R_XM);
                  // vy += dt * lam*(E - bm*vxm)
                  6'd13: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_XM, cpi_pkg::R_VXM, '0, cpi_pkg::R_T0);
                  6'd14: c = mk(cpi_pkg::OP_SUB, cpi_pkg::R_E, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd15: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd16: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_DT, cpi_pkg::R_VY, cpi_pkg::R_VY);
                  // vx += dt * (lam*bm)*vym
                  6'd17: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_XM, '0, cpi_pkg::R_T0);
                  6'd18: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_T0, cpi_pkg::R_B, '0, cpi_pkg::R_T0);
                  6'd19: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_DT, cpi_pkg::R_VX, cpi_pkg::R_VX);
                  6'd20: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VXM, cpi_pkg::R_DT, cpi_pkg::R_X, cpi_pkg::R_X);
                  6'd21: begin
                     c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_B, cpi_pkg::R_DT, cpi_pkg::R_Y, cpi_pkg::R_Y);
                     last = 1'b1;
                  end
                  default: last = 1'b1;
               endcase
            end
            default: begin
               case (pc_ff)
                  6'd3: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_B, '0, cpi_pkg::R_T0);
                  6'd4: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_T0, cpi_pkg::R_VY, '0, cpi_pkg::R_T0);
                  6'd5: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_H, cpi_pkg::R_VX, cpi_pkg::R_VX);
                  6'd6: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B, cpi_pkg::R_VX, '0, cpi_pkg::R_T0);
                  6'd7: c = mk(cpi_pkg::OP_SUB, cpi_pkg::R_E, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd8: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd9: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_H, cpi_pkg::R_VY, cpi_pkg::R_VY);
                  6'd10: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VY, cpi_pkg::R_H, cpi_pkg::R_Y, cpi_pkg::R_Y);
                  6'd11: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VX, cpi_pkg::R_H, cpi_pkg::R_X, cpi_pkg::R_X);
                  6'd12: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_KAP, cpi_pkg::R_X, cpi_pkg::R_ONE, cpi_pkg::R_T0);
                  6'd13: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B0, cpi_pkg::R_T0, '0, cpi_pkg::R_B);
                  6'd14: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_B, cpi_pkg::R_VX, '0, cpi_pkg::R_T0);
                  6'd15: c = mk(cpi_pkg::OP_SUB, cpi_pkg::R_E, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd16: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_T0, '0, cpi_pkg::R_T0);
                  6'd17: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_H, cpi_pkg::R_VY, cpi_pkg::R_VY);
                  6'd18: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_LAM, cpi_pkg::R_B, '0, cpi_pkg::R_T0);
                  6'd19: c = mk(cpi_pkg::OP_MUL, cpi_pkg::R_T0, cpi_pkg::R_VY, '0, cpi_pkg::R_T0);
                  6'd20: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_T0, cpi_pkg::R_H, cpi_pkg::R_VX, cpi_pkg::R_VX);
                  6'd21: c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VY, cpi_pkg::R_H, cpi_pkg::R_Y, cpi_pkg::R_Y);
                  6'd22: begin
                     c = mk(cpi_pkg::OP_MAC, cpi_pkg::R_VX, cpi_pkg::R_H, cpi_pkg::R_X, cpi_pkg::R_X);
                     last = 1'b1;
                  end
                  default: last = 1'b1;
               endcase
            end
         endcase
      end
   end

   // Sequencer: a load is a single operation, a step walks the program.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      phase_in = phase_ff;
      mode_in  = mode_ff;
      cmd      = mk(cpi_pkg::OP_NOP, '0, '0, '0, '0);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = mode;
               pc_in    = '0;
               phase_in = 1'b0;
               if (start_kind) begin
                  cmd      = mk(cpi_pkg::OP_CLR, '0, '0, '0, '0);
                  state_in = S_RUN;
               end else begin
                  cmd      = mk(cpi_pkg::OP_LOAD, '0, '0, '0, '0);
                  state_in = S_DONE;
               end
            end
         end
         S_RUN: begin
            cmd = c;
            if ((c.op == cpi_pkg::OP_MUL || c.op == cpi_pkg::OP_MAC) && !phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               pc_in    = pc_ff + 6'd1;
               if (last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // Hold the finished state until the result register can take it.
            if (result_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         phase_ff <= 1'b0;
         mode_ff  <= cpi_pkg::MODE_EULER;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
      end
   end

   assign mul_phase = phase_ff && state_ff == S_RUN;
   assign done      = state_ff == S_DONE;

endmodule

[rtl/core/charged_particle_integrator_top.sv]
// ----------------------------------------------------------------------------
// Charged particle integrator top level
// A load is a single operation; a step runs the program of its scheme (Euler,
// Euler-Cromer, RK2, Verlet), paced by the single shared multiplier, which
// holds each product for a multiply phase and a write phase.
// One item at a time; the next is taken in the cycle after the result is
// registered, also while that result waits in the output.
// Synchronous reset restores register defaults and clears the state.
// ----------------------------------------------------------------------------
module charged_particle_integrator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [31:0] req_init_x,
   input  logic signed [31:0] req_init_y,
   input  logic signed [31:0] req_init_vx,
   input  logic signed [31:0] req_init_vy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic [31:0]        rsp_steps_done,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [1:0]         mode_ff;
   logic signed [31:0] dt_ff, lam_ff, b0_ff, kap_ff, e_ff;
   logic               busy_ff, busy_in;
   logic               kind_ff;
   logic [31:0]        steps_ff;
   logic               start, done, mul_phase, clip;
   logic signed [31:0] st_x, st_y, st_vx, st_vy;
   logic               out_v_ff;
   logic               out_free;
   cpi_pkg::cmd_type   cmd;

   assign pready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cpi_pkg::MODE_EULER;
         dt_ff   <= 32'sd65;
         lam_ff  <= 32'sd65536;
         b0_ff   <= 32'sd65536;
         kap_ff  <= '0;
         e_ff    <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr)
            cpi_pkg::ADDR_MODE:   mode_ff <= pwdata[1:0];
            cpi_pkg::ADDR_DT:     dt_ff   <= pwdata;
            cpi_pkg::ADDR_LAMBDA: lam_ff  <= pwdata;
            cpi_pkg::ADDR_B0:     b0_ff   <= pwdata;
            cpi_pkg::ADDR_KAPPA:  kap_ff  <= pwdata;
            cpi_pkg::ADDR_EFIELD: e_ff    <= pwdata;
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (paddr)
         cpi_pkg::ADDR_MODE:   prdata = {30'd0, mode_ff};
         cpi_pkg::ADDR_DT:     prdata = dt_ff;
         cpi_pkg::ADDR_LAMBDA: prdata = lam_ff;
         cpi_pkg::ADDR_B0:     prdata = b0_ff;
         cpi_pkg::ADDR_KAPPA:  prdata = kap_ff;
         cpi_pkg::ADDR_EFIELD: prdata = e_ff;
         default:              prdata = '0;
      endcase
   end

   // Accept when no item is in work; the result slot is checked only when
   // this item finishes.
   assign req_stall = busy_ff;
   assign start     = req_valid && !busy_ff;
   assign out_free  = !(out_v_ff && rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && done && out_free) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         steps_ff <= '0;
         kind_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (start) begin
            kind_ff <= req_kind;
            steps_ff <= req_kind ? steps_ff + 32'd1 : 32'd0;
         end
         if (busy_ff && done && out_free) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (busy_ff && done && out_free) begin
         rsp_pos_x      <= st_x;
         rsp_pos_y      <= st_y;
         rsp_vel_x      <= st_vx;
         rsp_vel_y      <= st_vy;
         rsp_steps_done <= steps_ff;
         rsp_saturated  <= kind_ff & clip;
      end
   end

   assign rsp_valid = out_v_ff;

   cpi_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_kind  (req_kind),
      .mode        (mode_ff),
      .result_free (out_free),
      .cmd         (cmd),
      .mul_phase   (mul_phase),
      .done        (done)
   );

   cpi_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .mul_phase  (mul_phase),
      .init_x     (req_init_x),
      .init_y     (req_init_y),
      .init_vx    (req_init_vx),
      .init_vy    (req_init_vy),
      .cfg_dt     (dt_ff),
      .cfg_lambda (lam_ff),
      .cfg_b0     (b0_ff),
      .cfg_kappa  (kap_ff),
      .cfg_efield (e_ff),
      .st_x       (st_x),
      .st_y       (st_y),
      .st_vx      (st_vx),
      .st_vy      (st_vy),
      .clip       (clip)
   );

endmodule
